>>> rtl/ordered_keyed_flag_table_unit_assert.svh
// Assertion macros shared by the checker of the keyed flag table unit.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ORDERED_KEYED_FLAG_TABLE_UNIT_ASSERT_SVH
`define ORDERED_KEYED_FLAG_TABLE_UNIT_ASSERT_SVH

// Antecedent in the same cycle implies the consequent, outside reset.
`define OKFT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies the consequent in the next cycle, outside reset.
`define OKFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// Antecedent implies the consequent in the next cycle, also through reset.
`define OKFT_ASSERT_NEXT_ANY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/okft_pkg.sv
// Package of the keyed flag table unit: request, response and slot types.
// Used by the sequencer, the slot memory, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package okft_pkg;

    localparam int GROUPS_DEF = 8;
    localparam int SLOTS_DEF  = 16;
    localparam int KEY_W      = 8;
    localparam int FLAG_W     = 8;
    localparam int ENTRY_W    = KEY_W + FLAG_W;
    localparam int CMP_W      = 7;

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_DELETE = 3'd1,
        FN_QUERY  = 3'd2,
        FN_UPDATE = 3'd3,
        FN_CLEAR  = 3'd4
    } okft_func_t;

    typedef struct packed {
        logic [2:0]        func;
        logic [3:0]        position;
        logic              auto_place;
        logic [2:0]        bit_index;
        logic              whole_byte;
        logic [FLAG_W-1:0] flag_value;
        logic              all_keys;
        logic [KEY_W-1:0]  key;
        logic [2:0]        group;
    } okft_req_t;

    typedef struct packed {
        logic [FLAG_W-1:0] flag_data;
        logic              ok;
    } okft_resp_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [FLAG_W-1:0] flags;
    } okft_entry_t;

    localparam okft_entry_t ENTRY_EMPTY = '0;

endpackage

>>> rtl/okft_ram.sv
// Simple dual-port slot memory with one write port and one registered read port.
// Depends on okft_pkg for the slot entry type.
`timescale 1ns / 1ps

module okft_ram
    import okft_pkg::*;
#(
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  okft_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output okft_entry_t       rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    okft_entry_t mem [DEPTH];
    okft_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/okft_seq.sv
// Request sequencer of the keyed flag table unit: clearing pass, slot scan,
// and the shift, update and clear passes over the slot memory.
// Depends on okft_pkg; drives the ports of okft_ram.
`timescale 1ns / 1ps

module okft_seq
    import okft_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF,
    parameter int SLOTS  = SLOTS_DEF,
    parameter int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1,
    parameter int SW     = $clog2(SLOTS),
    parameter int AW     = GW + SW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  okft_req_t     req,
    output logic          resp_valid,
    input  logic          resp_ready,
    output okft_resp_t    resp,
    output logic          ram_wr_en,
    output logic [AW-1:0] ram_wr_addr,
    output okft_entry_t   ram_wr_data,
    output logic          ram_rd_en,
    output logic [AW-1:0] ram_rd_addr,
    input  okft_entry_t   ram_rd_data
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_PLAN,
        ST_PASS,
        ST_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     init_addr_reg, init_addr_next;
    okft_req_t         req_reg, req_next;
    logic [GW-1:0]     gidx_reg, gidx_next;
    logic [SW-1:0]     rd_idx_reg, rd_idx_next;
    logic [SW-1:0]     end_idx_reg, end_idx_next;
    logic              up_reg, up_next;
    logic              rd_more_reg, rd_more_next;
    logic              dat_vld_reg, dat_vld_next;
    logic [SW-1:0]     dat_idx_reg, dat_idx_next;
    logic              found_reg, found_next;
    logic [SW-1:0]     found_idx_reg, found_idx_next;
    logic [FLAG_W-1:0] found_flags_reg, found_flags_next;
    logic              empty_reg, empty_next;
    logic [SW-1:0]     empty_idx_reg, empty_idx_next;
    logic              last_occ_reg, last_occ_next;
    okft_entry_t       carry_reg, carry_next;
    logic              ok_reg, ok_next;
    logic [FLAG_W-1:0] data_reg, data_next;

    always_comb begin
        okft_entry_t       cur;
        logic [FLAG_W-1:0] upd_bit;
        logic [FLAG_W-1:0] upd_flags;
        logic              pos_ok;
        logic [SW-1:0]     ins_pos;

        state_next       = state_reg;
        init_addr_next   = init_addr_reg;
        req_next         = req_reg;
        gidx_next        = gidx_reg;
        rd_idx_next      = rd_idx_reg;
        end_idx_next     = end_idx_reg;
        up_next          = up_reg;
        rd_more_next     = rd_more_reg;
        dat_vld_next     = 1'b0;
        dat_idx_next     = dat_idx_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        found_flags_next = found_flags_reg;
        empty_next       = empty_reg;
        empty_idx_next   = empty_idx_reg;
        last_occ_next    = last_occ_reg;
        carry_next       = carry_reg;
        ok_next          = ok_reg;
        data_next        = data_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = {gidx_reg, dat_idx_reg};
        ram_wr_data = carry_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = {gidx_reg, rd_idx_reg};

        cur       = ram_rd_data;
        upd_bit   = 8'(1) << req_reg.bit_index;
        upd_flags = req_reg.whole_byte ? req_reg.flag_value
                  : ((cur.flags & ~upd_bit)
                     | ((req_reg.flag_value != '0) ? upd_bit : '0));
        pos_ok    = req_reg.auto_place ? empty_reg
                  : (CMP_W'(req_reg.position) < CMP_W'(SLOTS));
        ins_pos   = req_reg.auto_place ? empty_idx_reg : SW'(req_reg.position);

        if ((state_reg == ST_SCAN || state_reg == ST_PASS) && rd_more_reg) begin
            ram_rd_en    = 1'b1;
            dat_vld_next = 1'b1;
            dat_idx_next = rd_idx_reg;
            if (rd_idx_reg == end_idx_reg) begin
                rd_more_next = 1'b0;
            end else if (up_reg) begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end else begin
                rd_idx_next = rd_idx_reg - 1'b1;
            end
        end

        unique case (state_reg)
            ST_INIT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = init_addr_reg;
                ram_wr_data = ENTRY_EMPTY;
                if (init_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end else begin
                    init_addr_next = init_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (req_valid) begin
                    req_next      = req;
                    gidx_next     = GW'(req.group);
                    found_next    = 1'b0;
                    empty_next    = 1'b0;
                    last_occ_next = 1'b0;
                    ok_next       = 1'b0;
                    data_next     = '0;
                    rd_idx_next   = '0;
                    end_idx_next  = SW'(SLOTS - 1);
                    up_next       = 1'b1;
                    rd_more_next  = 1'b1;
                    carry_next    = ENTRY_EMPTY;
                    if (CMP_W'(req.group) >= CMP_W'(GROUPS)) begin
                        state_next = ST_RESP;
                    end else begin
                        unique case (req.func) inside
                            FN_INSERT, FN_DELETE, FN_QUERY: state_next = ST_SCAN;
                            FN_UPDATE, FN_CLEAR:            state_next = ST_PASS;
                            default:                        state_next = ST_RESP;
                        endcase
                    end
                end
            end
            ST_SCAN: begin
                if (dat_vld_reg) begin
                    if (!found_reg && cur.key == req_reg.key) begin
                        found_next       = 1'b1;
                        found_idx_next   = dat_idx_reg;
                        found_flags_next = cur.flags;
                    end
                    if (!empty_reg && cur == ENTRY_EMPTY) begin
                        empty_next     = 1'b1;
                        empty_idx_next = dat_idx_reg;
                    end
                    if (dat_idx_reg == SW'(SLOTS - 1)) begin
                        last_occ_next = (cur != ENTRY_EMPTY);
                    end
                end
                if (!rd_more_reg && !dat_vld_reg) begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                rd_more_next = 1'b1;
                state_next   = ST_RESP;
                unique case (req_reg.func) inside
                    FN_INSERT: begin
                        if (!found_reg && pos_ok && !last_occ_reg) begin
                            rd_idx_next  = ins_pos;
                            end_idx_next = SW'(SLOTS - 1);
                            up_next      = 1'b1;
                            carry_next   = {req_reg.key, req_reg.flag_value};
                            state_next   = ST_PASS;
                        end
                    end
                    FN_DELETE: begin
                        if (found_reg) begin
                            rd_idx_next  = SW'(SLOTS - 1);
                            end_idx_next = found_idx_reg;
                            up_next      = 1'b0;
                            carry_next   = ENTRY_EMPTY;
                            state_next   = ST_PASS;
                        end
                    end
                    FN_QUERY: begin
                        ok_next = found_reg;
                        if (found_reg) begin
                            data_next = req_reg.whole_byte ? found_flags_reg
                                : {7'b0, found_flags_reg[req_reg.bit_index]};
                        end
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_PASS: begin
                if (dat_vld_reg) begin
                    case (req_reg.func) inside
                        FN_INSERT, FN_DELETE: begin
                            ram_wr_en   = 1'b1;
                            ram_wr_data = carry_reg;
                            carry_next  = cur;
                        end
                        FN_UPDATE: begin
                            ram_wr_en   = (cur.key != '0)
                                && (req_reg.all_keys || cur.key == req_reg.key);
                            ram_wr_data = {cur.key, upd_flags};
                        end
                        default: begin
                            ram_wr_en   = 1'b1;
                            ram_wr_data = ENTRY_EMPTY;
                        end
                    endcase
                end
                if (!rd_more_reg && !dat_vld_reg) begin
                    ok_next    = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (resp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            rd_more_reg   <= 1'b0;
            dat_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            rd_more_reg   <= rd_more_next;
            dat_vld_reg   <= dat_vld_next;
        end
        req_reg         <= req_next;
        gidx_reg        <= gidx_next;
        rd_idx_reg      <= rd_idx_next;
        end_idx_reg     <= end_idx_next;
        up_reg          <= up_next;
        dat_idx_reg     <= dat_idx_next;
        found_reg       <= found_next;
        found_idx_reg   <= found_idx_next;
        found_flags_reg <= found_flags_next;
        empty_reg       <= empty_next;
        empty_idx_reg   <= empty_idx_next;
        last_occ_reg    <= last_occ_next;
        carry_reg       <= carry_next;
        ok_reg          <= ok_next;
        data_reg        <= data_next;
    end

    assign req_ready      = (state_reg == ST_IDLE);
    assign resp_valid     = (state_reg == ST_RESP);
    assign resp.ok        = ok_reg;
    assign resp.flag_data = data_reg;

endmodule

>>> rtl/ordered_keyed_flag_table_unit.sv
// Query scans the group's slots; update and clear make a pass over them; insert and
// delete scan them and may then make a shifting pass, reading the slot memory one slot at a time.
// Throughput: one request at a time; the next is taken once the result is queued.
// Reset: a clearing pass writes every slot of the memory, and no request is taken
// until it is done.
`timescale 1ns / 1ps

module ordered_keyed_flag_table_unit
    import okft_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF,
    parameter int SLOTS  = SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // group, key, all_keys, flag_value, whole_byte, bit_index, auto_place, position
    input  logic [31:0] s_tdata,
    // func
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok, flag_data
    output logic [15:0] m_tdata
);

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SW = $clog2(SLOTS);
    localparam int AW = GW + SW;

    okft_req_t   req;
    okft_resp_t  resp;
    logic        resp_valid;
    logic        resp_ready;
    logic        ram_wr_en;
    logic        ram_rd_en;
    logic [AW-1:0] ram_wr_addr;
    logic [AW-1:0] ram_rd_addr;
    okft_entry_t ram_wr_data;
    okft_entry_t ram_rd_data;

    logic        m_tvalid_reg, m_tvalid_next;
    okft_resp_t  m_resp_reg, m_resp_next;

    assign req = {s_tuser, s_tdata[28:0]};

    okft_seq #(
        .GROUPS (GROUPS),
        .SLOTS  (SLOTS),
        .GW     (GW),
        .SW     (SW),
        .AW     (AW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req         (req),
        .resp_valid  (resp_valid),
        .resp_ready  (resp_ready),
        .resp        (resp),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    okft_ram #(
        .ADDR_W (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign resp_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_resp_next   = m_resp_reg;
        if (resp_ready) begin
            m_tvalid_next = resp_valid;
            if (resp_valid) begin
                m_resp_next = resp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_resp_reg <= m_resp_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_resp_reg};

endmodule

>>> rtl/okft_checker.sv
// Port checker of the keyed flag table unit, bound to the top level.
// Depends on the assertion macros in ordered_keyed_flag_table_unit_assert.svh.
`timescale 1ns / 1ps
`include "ordered_keyed_flag_table_unit_assert.svh"

module okft_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `OKFT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `OKFT_ASSERT_NEXT_ANY(a_reset_busy, !aresetn, !m_tvalid && !s_tready, "not busy after reset")
    `OKFT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second request taken while busy")
    `OKFT_ASSERT_IMPLY(a_fail_no_data, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'h00, "failed request carries data")

endmodule

bind ordered_keyed_flag_table_unit okft_checker u_okft_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench of ordered_keyed_flag_table_unit: directed and random requests
// are checked against a mirror of the slot table, on the stream ports alone.
// Depends on okft_pkg and the unit itself.
`timescale 1ns / 1ps

module testbench;
    import okft_pkg::*;

    localparam int GROUP_COUNT = GROUPS_DEF;
    localparam int SLOT_COUNT  = SLOTS_DEF;
    localparam int RANDOM_REQS = 1800;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 2 * SLOT_COUNT + 32;
    localparam int HOLD_AT     = 900;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [3:0]        position;
        logic              auto_place;
        logic [2:0]        bit_index;
        logic              whole_byte;
        logic [FLAG_W-1:0] flag_value;
        logic              all_keys;
        logic [KEY_W-1:0]  key;
        logic [2:0]        group;
    } table_req_t;

    class flag_table_mirror;
        okft_entry_t slots [GROUP_COUNT][SLOT_COUNT];
        okft_resp_t  answers [$];
        int          faults;
        int          checked;
        int          requests [8];
        int          granted [8];

        function new();
            foreach (slots[g, i]) slots[g][i] = ENTRY_EMPTY;
            faults  = 0;
            checked = 0;
            foreach (requests[i]) begin
                requests[i] = 0;
                granted[i]  = 0;
            end
        endfunction

        function int locate(int g, logic [KEY_W-1:0] key);
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (slots[g][i].key == key) return i;
            end
            return -1;
        endfunction

        function int outstanding();
            return answers.size();
        endfunction

        function void take_request(logic [2:0] func, table_req_t req);
            okft_resp_t  ans;
            int          g;
            int          at;
            logic [7:0]  mask;
            logic [7:0]  f;
            ans = '0;
            g = req.group;
            if (g < GROUP_COUNT) begin
                case (func)
                    FN_INSERT: begin
                        at = -1;
                        if (locate(g, req.key) < 0) begin
                            if (req.auto_place) begin
                                for (int i = 0; i < SLOT_COUNT; i++) begin
                                    if (slots[g][i] == ENTRY_EMPTY) begin
                                        at = i;
                                        break;
                                    end
                                end
                            end else if (req.position < SLOT_COUNT) begin
                                at = req.position;
                            end
                            if (at >= 0 && slots[g][SLOT_COUNT-1] == ENTRY_EMPTY) begin
                                for (int i = SLOT_COUNT - 1; i > at; i--)
                                    slots[g][i] = slots[g][i-1];
                                slots[g][at] = okft_entry_t'({req.key, req.flag_value});
                                ans.ok = 1'b1;
                            end
                        end
                    end
                    FN_DELETE: begin
                        at = locate(g, req.key);
                        if (at >= 0) begin
                            for (int i = at; i < SLOT_COUNT - 1; i++)
                                slots[g][i] = slots[g][i+1];
                            slots[g][SLOT_COUNT-1] = ENTRY_EMPTY;
                            ans.ok = 1'b1;
                        end
                    end
                    FN_QUERY: begin
                        at = locate(g, req.key);
                        if (at >= 0) begin
                            f = slots[g][at].flags;
                            ans.flag_data = req.whole_byte ? f : {7'd0, f[req.bit_index]};
                            ans.ok = 1'b1;
                        end
                    end
                    FN_UPDATE: begin
                        mask = 8'h01 << req.bit_index;
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (slots[g][i].key != '0 &&
                                (req.all_keys || slots[g][i].key == req.key)) begin
                                if (req.whole_byte)
                                    slots[g][i].flags = req.flag_value;
                                else if (req.flag_value != '0)
                                    slots[g][i].flags = slots[g][i].flags | mask;
                                else
                                    slots[g][i].flags = slots[g][i].flags & ~mask;
                            end
                        end
                        ans.ok = 1'b1;
                    end
                    FN_CLEAR: begin
                        for (int i = 0; i < SLOT_COUNT; i++) slots[g][i] = ENTRY_EMPTY;
                        ans.ok = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            requests[func]++;
            if (ans.ok) granted[func]++;
            answers.push_back(ans);
        endfunction

        function void check_response(logic [15:0] word);
            okft_resp_t got;
            okft_resp_t want;
            got = okft_resp_t'(word[8:0]);
            checked++;
            if (answers.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("Response ok=%0d flag_data=%02h with no request outstanding",
                             got.ok, got.flag_data);
                return;
            end
            want = answers.pop_front();
            if (got.ok !== want.ok || got.flag_data !== want.flag_data ||
                word[15:9] !== 7'd0) begin
                faults++;
                if (faults <= 10)
                    $display("Response %0d: expected ok=%0d flag_data=%02h, got word %04h",
                             checked, want.ok, want.flag_data, word);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    flag_table_mirror mirror = new();
    bit         steady = 1'b0;
    int         results_seen = 0;
    int         hold_left = 0;
    logic [7:0] key_pool [20];

    ordered_keyed_flag_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic table_req_t build_req(logic [2:0] group, logic [7:0] key,
                                             logic all_keys, logic [7:0] flag_value,
                                             logic whole_byte, logic [2:0] bit_index,
                                             logic auto_place, logic [3:0] position);
        table_req_t r;
        r.group      = group;
        r.key        = key;
        r.all_keys   = all_keys;
        r.flag_value = flag_value;
        r.whole_byte = whole_byte;
        r.bit_index  = bit_index;
        r.auto_place = auto_place;
        r.position   = position;
        return r;
    endfunction

    task automatic offer(input logic [2:0] func, input table_req_t req);
        if (!steady) begin
            while ($urandom_range(0, 99) < 34) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, req};
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        mirror.take_request(func, req);
    endtask

    // Outside the steady phase the receiver stalls at random, and once holds off long enough for the unit to back up.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                mirror.check_response(m_tdata);
                results_seen++;
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 34);
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timed out after %0d cycles without a request or response", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [2:0] func;
        logic [2:0] group;
        logic [7:0] key;
        int         pick;

        key_pool[0] = 8'hff;
        key_pool[1] = 8'h80;
        key_pool[2] = 8'h7f;
        key_pool[3] = 8'h01;
        for (int i = 4; i < 20; i++) key_pool[i] = 8'($urandom_range(2, 254));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-table corner cases, full last slot, every operation and bit mode.
        offer(FN_QUERY,  build_req(3'd0, 8'h05, 1'b0, 8'h00, 1'b1, 3'd0, 1'b0, 4'd0));
        offer(FN_QUERY,  build_req(3'd0, 8'h00, 1'b0, 8'h00, 1'b1, 3'd0, 1'b0, 4'd0));
        offer(FN_INSERT, build_req(3'd0, 8'h00, 1'b0, 8'h12, 1'b0, 3'd0, 1'b1, 4'd0));
        offer(FN_DELETE, build_req(3'd1, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0, 4'd0));
        offer(FN_INSERT, build_req(3'd7, 8'hff, 1'b0, 8'hff, 1'b0, 3'd0, 1'b1, 4'd0));
        offer(FN_INSERT, build_req(3'd7, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0, 4'd15));
        offer(FN_INSERT, build_req(3'd7, 8'h02, 1'b0, 8'h33, 1'b0, 3'd0, 1'b1, 4'd0));
        offer(FN_INSERT, build_req(3'd7, 8'hff, 1'b0, 8'h44, 1'b0, 3'd0, 1'b0, 4'd3));
        offer(FN_QUERY,  build_req(3'd7, 8'hff, 1'b0, 8'h00, 1'b1, 3'd0, 1'b0, 4'd0));
        offer(FN_QUERY,  build_req(3'd7, 8'hff, 1'b0, 8'h00, 1'b0, 3'd7, 1'b0, 4'd0));
        offer(FN_UPDATE, build_req(3'd7, 8'hff, 1'b0, 8'h00, 1'b0, 3'd7, 1'b0, 4'd0));
        offer(FN_UPDATE, build_req(3'd7, 8'h00, 1'b1, 8'h80, 1'b0, 3'd0, 1'b0, 4'd0));
        offer(FN_QUERY,  build_req(3'd7, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0, 4'd0));
        offer(FN_UPDATE, build_req(3'd7, 8'h00, 1'b1, 8'h5a, 1'b1, 3'd0, 1'b0, 4'd0));
        offer(FN_UPDATE, build_req(3'd7, 8'h33, 1'b0, 8'hff, 1'b1, 3'd0, 1'b0, 4'd0));
        offer(FN_QUERY,  build_req(3'd7, 8'hff, 1'b0, 8'h00, 1'b1, 3'd0, 1'b0, 4'd0));
        offer(FN_DELETE, build_req(3'd7, 8'h01, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0, 4'd0));
        offer(FN_DELETE, build_req(3'd7, 8'h03, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0, 4'd0));
        offer(FN_INSERT, build_req(3'd7, 8'h80, 1'b0, 8'h0f, 1'b0, 3'd0, 1'b0, 4'd0));
        offer(FN_QUERY,  build_req(3'd7, 8'hff, 1'b0, 8'h00, 1'b0, 3'd1, 1'b0, 4'd0));
        offer(FN_CLEAR,  build_req(3'd7, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0, 4'd0));
        offer(FN_QUERY,  build_req(3'd7, 8'hff, 1'b0, 8'h00, 1'b1, 3'd0, 1'b0, 4'd0));
        offer(3'(FN_CLEAR) + 3'd1, build_req(3'd2, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0, 1'b0, 4'd0));
        offer(3'(FN_CLEAR) + 3'd3, build_req(3'd5, 8'hff, 1'b1, 8'hff, 1'b1, 3'd7, 1'b1, 4'd15));

        // Random: a few busy groups and a small key set, so lists fill, collide and shift.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            steady = (n >= 400 && n < 700);
            pick = $urandom_range(0, 99);
            if (pick < 45)      func = FN_INSERT;
            else if (pick < 60) func = FN_DELETE;
            else if (pick < 80) func = FN_QUERY;
            else if (pick < 98) func = FN_UPDATE;
            else if (pick < 99) func = FN_CLEAR;
            else                func = 3'(FN_CLEAR) + 3'($urandom_range(1, 3));
            pick = $urandom_range(0, 99);
            if (pick < 40)      group = 3'd0;
            else if (pick < 65) group = 3'd1;
            else if (pick < 80) group = 3'd2;
            else                group = 3'($urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            if (pick < 8)       key = 8'h00;
            else if (pick < 20) key = 8'($urandom_range(0, 255));
            else                key = key_pool[$urandom_range(0, 19)];
            offer(func, build_req(group, key, $urandom_range(0, 3) == 0,
                                  ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))));
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (mirror.outstanding() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Requests: %0d inserts (%0d placed), %0d deletes (%0d found), %0d queries (%0d hit)",
                 mirror.requests[FN_INSERT], mirror.granted[FN_INSERT],
                 mirror.requests[FN_DELETE], mirror.granted[FN_DELETE],
                 mirror.requests[FN_QUERY], mirror.granted[FN_QUERY]);
        $display("%0d updates, %0d group clears, %0d responses checked, %0d mismatches",
                 mirror.requests[FN_UPDATE], mirror.requests[FN_CLEAR],
                 mirror.checked, mirror.faults);
        if (mirror.faults == 0 && mirror.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
